/* rtl/tavr_pkg.sv */
// shared types and constants for the three-axis velocity ramp
// request and result structs, lane control struct, register indexes, fixed-point shifts
package tavr_pkg;

  localparam int TIME_FRAC   = 16;
  localparam int DRIVE_FRAC  = 14;
  localparam int LIN_SHIFT   = TIME_FRAC;
  localparam int QUAD_SHIFT  = 2 * TIME_FRAC + 1;
  localparam int DV_SHIFT    = DRIVE_FRAC + TIME_FRAC;
  localparam int REG_W       = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_AXES    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Z   = 3'd5;

  typedef struct packed {
    logic signed [15:0] drive_x;
    logic signed [15:0] drive_y;
    logic signed [15:0] drive_z;
    logic        [15:0] tick_time;
  } tavr_in_t;

  typedef struct packed {
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] speed_z;
  } tavr_out_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic commit;
  } tavr_ctl_t;

endpackage

/* rtl/tavr_lane.sv */
// one axis lane: velocity register, two multiply stages, displacement and velocity update
// depends on tavr_pkg
module tavr_lane import tavr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  tavr_ctl_t           ctl,
  input  logic signed [15:0]  drive,
  input  logic        [15:0]  tick,
  input  logic [REG_W-1:0]    accel,
  input  logic [REG_W-1:0]    vmax,
  output logic [31:0]         vel,
  output logic [31:0]         vel_upd,
  output logic [31:0]         disp
);

  logic signed [15:0] drive_r;
  logic        [15:0] tick_r;
  logic signed [31:0] vel_r;
  logic        [46:0] at_r;
  logic signed [48:0] vt_r;
  logic        [62:0] att_r;
  logic signed [63:0] dat_r;
  logic signed [32:0] lin_r;

  logic signed [48:0] vt_adj;
  logic signed [32:0] lin_nxt;
  logic        [29:0] quad;
  logic signed [33:0] disp_sum;
  logic signed [31:0] disp_sat;
  logic signed [63:0] dat_adj;
  logic signed [33:0] dv;
  logic signed [34:0] vsum;
  logic signed [34:0] lim;
  logic signed [34:0] nlim;
  logic        [30:0] dec;
  logic signed [32:0] vdown;
  logic signed [31:0] vel_nxt;

  // truncation toward zero: bias negatives before the arithmetic shift
  assign vt_adj   = vt_r + $signed({33'd0, {LIN_SHIFT{vt_r[48]}}});
  assign lin_nxt  = vt_adj[48:LIN_SHIFT];
  assign quad     = att_r[62:QUAD_SHIFT];
  assign disp_sum = {lin_r[32], lin_r} + {4'd0, quad};

  always_comb begin
    if (disp_sum[33:31] == 3'b000 || disp_sum[33:31] == 3'b111) begin
      disp_sat = disp_sum[31:0];
    end else if (disp_sum[33]) begin
      disp_sat = 32'sh8000_0000;
    end else begin
      disp_sat = 32'sh7fff_ffff;
    end
  end

  assign dat_adj = dat_r + $signed({34'd0, {DV_SHIFT{dat_r[63]}}});
  assign dv      = dat_adj[63:DV_SHIFT];
  assign vsum    = {{3{vel_r[31]}}, vel_r} + {dv[33], dv};
  assign lim     = {4'd0, vmax};
  assign nlim    = -lim;
  assign dec     = at_r[46:TIME_FRAC];
  assign vdown   = (vel_r > 0) ? ({vel_r[31], vel_r} - {2'd0, dec})
                               : ({vel_r[31], vel_r} + {2'd0, dec});

  always_comb begin
    if (drive_r != '0) begin
      if (vsum > lim) begin
        vel_nxt = lim[31:0];
      end else if (vsum < nlim) begin
        vel_nxt = nlim[31:0];
      end else begin
        vel_nxt = vsum[31:0];
      end
    end else if (vel_r > 0) begin
      vel_nxt = (vdown < 0) ? 32'sd0 : vdown[31:0];
    end else begin
      vel_nxt = (vdown > 0) ? 32'sd0 : vdown[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      drive_r <= drive;
      tick_r  <= tick;
    end
    if (ctl.mul1) begin
      at_r <= accel * tick_r;
      vt_r <= vel_r * $signed({1'b0, tick_r});
    end
    if (ctl.mul2) begin
      att_r <= at_r * tick_r;
      dat_r <= drive_r * $signed({1'b0, at_r});
      lin_r <= lin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r <= '0;
    end else if (ctl.commit) begin
      vel_r <= vel_nxt;
    end
  end

  assign vel     = vel_r;
  assign vel_upd = vel_nxt;
  assign disp    = (drive_r == '0 && vel_r == '0) ? 32'd0 : disp_sat;

  a_driven_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit && drive_r != '0 |=>
      (vel_r <= $signed({1'b0, $past(vmax)})) && (vel_r >= -$signed({1'b0, $past(vmax)})))
    else $error("driven velocity outside limit");

  a_coast_toward_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit && drive_r == '0 && vel_r > 0 |=> vel_r >= 0 && vel_r <= $past(vel_r))
    else $error("undriven velocity did not decay toward zero");

endmodule

/* rtl/tavr_merge.sv */
// merging stage: at-rest masking across lanes and the result register
// depends on tavr_pkg
module tavr_merge import tavr_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        commit,
  input  logic [NUM_AXES-1:0][31:0]   vel,
  input  logic [NUM_AXES-1:0][31:0]   vel_upd,
  input  logic [NUM_AXES-1:0][31:0]   disp,
  input  logic                        out_stall,
  output logic                        out_valid,
  output tavr_out_t                   out_data
);

  logic      out_valid_r;
  tavr_out_t out_data_r;
  tavr_out_t out_data_nxt;
  logic      moving;

  assign moving = (vel[0] != '0) || (vel[1] != '0) || (vel[2] != '0);

  always_comb begin
    out_data_nxt.disp_x  = moving ? disp[0] : 32'd0;
    out_data_nxt.disp_y  = moving ? disp[1] : 32'd0;
    out_data_nxt.disp_z  = moving ? disp[2] : 32'd0;
    out_data_nxt.speed_x = vel_upd[0];
    out_data_nxt.speed_y = vel_upd[1];
    out_data_nxt.speed_z = vel_upd[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r && out_data_r.speed_x == $signed(vel[0])
               && out_data_r.speed_y == $signed(vel[1])
               && out_data_r.speed_z == $signed(vel[2]))
    else $error("reported speed differs from stored velocity");

endmodule

/* rtl/three_axis_velocity_ramp.sv */
// top level of the three-axis velocity ramp: config registers, sequencer, lanes, merge
// depends on tavr_pkg, tavr_lane, tavr_merge
//
//   channel | ports                          | request
//   in      | in_valid, in_stall, in_data    | drive per axis and tick time
//   out     | out_valid, out_stall, out_data | displacement and new speed per axis
//   cfg     | cfg_we, cfg_index, cfg_data    | accel and max speed per axis
//
// each request steps through capture, a*t and v*t, the second multiply, commit
// the chained multiplies in each lane set these steps; the three axes run side by side
// synchronous reset clears velocities, registers and the sequencer
// a finished result sits in the output register while the next request is taken;
// commit waits only while that register is still full and stalled
module three_axis_velocity_ramp import tavr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tavr_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tavr_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL1, ST_MUL2, ST_COMMIT} state_t;

  state_t                      state_r;
  logic [REG_W-1:0]            accel_r [NUM_AXES];
  logic [REG_W-1:0]            vmax_r  [NUM_AXES];
  logic signed [15:0]          drive_a [NUM_AXES];
  logic [NUM_AXES-1:0][31:0]   vel;
  logic [NUM_AXES-1:0][31:0]   vel_upd;
  logic [NUM_AXES-1:0][31:0]   disp;
  tavr_ctl_t                   ctl;
  logic                        out_free;

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign ctl.load   = in_valid && !in_stall;
  assign ctl.mul1   = (state_r == ST_MUL1);
  assign ctl.mul2   = (state_r == ST_MUL2);
  assign ctl.commit = (state_r == ST_COMMIT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE:   if (in_valid) state_r <= ST_MUL1;
        ST_MUL1:   state_r <= ST_MUL2;
        ST_MUL2:   state_r <= ST_COMMIT;
        ST_COMMIT: if (out_free) state_r <= ST_IDLE;
        default:   state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        accel_r[i] <= '0;
        vmax_r[i]  <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL_X: accel_r[0] <= cfg_data;
        REG_ACCEL_Y: accel_r[1] <= cfg_data;
        REG_ACCEL_Z: accel_r[2] <= cfg_data;
        REG_MAX_X:   vmax_r[0]  <= cfg_data;
        REG_MAX_Y:   vmax_r[1]  <= cfg_data;
        REG_MAX_Z:   vmax_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign drive_a[0] = in_data.drive_x;
  assign drive_a[1] = in_data.drive_y;
  assign drive_a[2] = in_data.drive_z;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    tavr_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .drive   (drive_a[g]),
      .tick    (in_data.tick_time),
      .accel   (accel_r[g]),
      .vmax    (vmax_r[g]),
      .vel     (vel[g]),
      .vel_upd (vel_upd[g]),
      .disp    (disp[g])
    );
  end

  tavr_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (ctl.commit),
    .vel       (vel),
    .vel_upd   (vel_upd),
    .disp      (disp),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* bench/tavr_ramp_checker.sv */
`timescale 1ns / 100ps
// checker for the three-axis velocity ramp: keeps its own velocity and register copies,
// predicts displacement and new speed for each accepted request and compares in order
// depends on tavr_pkg
module tavr_ramp_checker import tavr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  tavr_in_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  tavr_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   pending,
  output int                   results_seen
);

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int     OUT_W   = $bits(tavr_out_t);

  logic [REG_W-1:0] accel [NUM_AXES];
  logic [REG_W-1:0] speed_cap [NUM_AXES];
  int               velocity [NUM_AXES];
  tavr_out_t        expected_motion [$];

  function automatic longint trunc_shift(input longint x, input int s);
    if (x >= 0) return x >>> s;
    return -((-x) >>> s);
  endfunction

  function automatic longint clip32(input longint x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  function automatic string field_name(input int k);
    case (k)
      0: return "disp_x";
      1: return "disp_y";
      2: return "disp_z";
      3: return "speed_x";
      4: return "speed_y";
      default: return "speed_z";
    endcase
  endfunction

  // displacement from the old velocity, then the velocity update
  function automatic tavr_out_t predict_motion(input tavr_in_t req);
    longint          drv [NUM_AXES];
    longint          disp [NUM_AXES];
    longint          v, lin, quad, dv, dec, lim;
    longint unsigned a, t, at;
    logic            moving;
    tavr_out_t       res;
    drv[0] = longint'(req.drive_x);
    drv[1] = longint'(req.drive_y);
    drv[2] = longint'(req.drive_z);
    t = req.tick_time;
    moving = (velocity[0] != 0) || (velocity[1] != 0) || (velocity[2] != 0);
    for (int i = 0; i < NUM_AXES; i++) begin
      v = velocity[i];
      a = accel[i];
      disp[i] = 0;
      if (moving && !(drv[i] == 0 && v == 0)) begin
        lin = trunc_shift(v * longint'(t), LIN_SHIFT);
        quad = longint'((a * t * t) >> QUAD_SHIFT);
        disp[i] = clip32(lin + quad);
      end
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      v = velocity[i];
      a = accel[i];
      at = a * t;
      lim = longint'(speed_cap[i]);
      if (drv[i] != 0) begin
        dv = trunc_shift(drv[i] * longint'(at), DV_SHIFT);
        v = v + dv;
        if (v > lim) v = lim;
        else if (v < -lim) v = -lim;
      end else begin
        dec = longint'(at >> LIN_SHIFT);
        if (v > 0) begin
          v = v - dec;
          if (v < 0) v = 0;
        end else begin
          v = v + dec;
          if (v > 0) v = 0;
        end
      end
      velocity[i] = int'(v);
    end
    res.disp_x  = disp[0][31:0];
    res.disp_y  = disp[1][31:0];
    res.disp_z  = disp[2][31:0];
    res.speed_x = velocity[0];
    res.speed_y = velocity[1];
    res.speed_z = velocity[2];
    return res;
  endfunction

  always @(posedge clk) begin
    tavr_out_t   want;
    logic [31:0] w, g;
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        accel[i] = '0;
        speed_cap[i] = '0;
        velocity[i] = 0;
      end
      expected_motion.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ACCEL_X: accel[0] = cfg_data;
          REG_ACCEL_Y: accel[1] = cfg_data;
          REG_ACCEL_Z: accel[2] = cfg_data;
          REG_MAX_X:   speed_cap[0] = cfg_data;
          REG_MAX_Y:   speed_cap[1] = cfg_data;
          REG_MAX_Z:   speed_cap[2] = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_motion.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with no request outstanding", results_seen);
        end else begin
          want = expected_motion.pop_front();
          for (int k = 0; k < 6; k++) begin
            w = want[OUT_W-1-32*k -: 32];
            g = out_data[OUT_W-1-32*k -: 32];
            if (w !== g) begin
              mismatches++;
              if (mismatches <= 10)
                $display("%s wrong on result %0d: expected %0d got %0d",
                         field_name(k), results_seen, $signed(w), $signed(g));
            end
          end
        end
      end
      if (in_valid && !in_stall) expected_motion.push_back(predict_motion(in_data));
    end
    pending = expected_motion.size();
  end

endmodule

/* bench/tb_three_axis_velocity_ramp.sv */
`timescale 1ns / 100ps
// top of the velocity ramp bench: clock, reset, register profiles, tick requests
// with bursty sending and patterned output stalls; verdict from tavr_ramp_checker
// depends on tavr_pkg, three_axis_velocity_ramp, tavr_ramp_checker
module tb_three_axis_velocity_ramp;
  import tavr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int RANDOM_PHASES   = 8;
  localparam int TICKS_PER_PHASE = 80;
  localparam int SETTLE_CYCLES   = 8;

  typedef enum logic [1:0] {STALL_NONE, STALL_SCATTER, STALL_RUNS, STALL_PERIODIC} stall_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  tavr_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  tavr_out_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data  = '0;

  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_run   = 0;
  int          stall_count = 0;
  int          gap_max     = 0;
  int          burst_left  = 0;
  int          ticks_sent  = 0;
  int          profiles_loaded = 0;
  int          mismatches, pending, results_seen;

  three_axis_velocity_ramp u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tavr_ramp_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    stall_count++;
    if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_SCATTER: out_stall <= ($urandom_range(0, 99) < 35);
        STALL_RUNS: begin
          if ($urandom_range(0, 11) == 0) begin
            stall_run = $urandom_range(2, 14);
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
        default: out_stall <= (stall_count % 6) >= 4;
      endcase
    end
  end

  initial begin
    #5_000_000;
    $display("three_axis_velocity_ramp test failed");
    $finish;
  end

  function automatic tavr_in_t make_tick(input logic signed [15:0] dx, dy, dz,
                                         input logic [15:0] t);
    tavr_in_t r;
    r.drive_x = dx;
    r.drive_y = dy;
    r.drive_z = dz;
    r.tick_time = t;
    return r;
  endfunction

  function automatic logic signed [15:0] rand_drive();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'sd0;
      4: return 16'sd16384;
      5: return -16'sd16384;
      6: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic [15:0] rand_time();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [REG_W-1:0] rand_reg();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return REG_W'($urandom) >> $urandom_range(0, 22);
    endcase
  endfunction

  // called at a falling edge with the block idle; also pokes one unused index
  task automatic write_profile(input logic [REG_W-1:0] ax, ay, az, mx, my, mz);
    logic [REG_W-1:0]     vals [6];
    logic [CFG_IDX_W-1:0] regs [6];
    vals = '{ax, ay, az, mx, my, mz};
    regs = '{REG_ACCEL_X, REG_ACCEL_Y, REG_ACCEL_Z, REG_MAX_X, REG_MAX_Y, REG_MAX_Z};
    for (int k = 0; k < 6; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      @(negedge clk);
    end
    cfg_index <= (profiles_loaded % 2 == 0) ? REG_SPARE_A : REG_SPARE_B;
    cfg_data  <= REG_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    profiles_loaded++;
  endtask

  task automatic send_tick(input tavr_in_t item);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic idle_wait();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    idle_wait();

    // from rest: first request moves nothing, undriven axes at rest stay put
    stall_mode = STALL_SCATTER;
    gap_max = 3;
    write_profile(31'h0004_0000, 31'h0001_0000, 31'h0000_8000,
                  31'h0002_0000, 31'h7FFF_FFFF, 31'h0001_0000);
    send_tick(make_tick(16384, 0, 0, 16'h8000));
    send_tick(make_tick(16384, 0, 0, 16'h8000));
    send_tick(make_tick(-16384, 16384, 0, 16'hFFFF));
    send_tick(make_tick(-32768, 32767, -1, 16'h0001));
    send_tick(make_tick(0, 0, 0, 16'h0000));
    send_tick(make_tick(0, 0, 0, 16'hFFFF));
    send_tick(make_tick(0, 0, 0, 16'hFFFF));
    send_tick(make_tick(0, 0, 0, 16'hFFFF));
    send_tick(make_tick(16384, -16384, 16384, 16'hFFFF));
    send_tick(make_tick(16384, -16384, 16384, 16'hFFFF));
    idle_wait();

    // limit lowered below the current speed
    write_profile(31'h0000_0100, 31'h0000_0100, 31'h0000_0100,
                  31'h0000_4000, 31'h0000_4000, 31'h0000_4000);
    send_tick(make_tick(16384, 0, -16384, 16'h4000));
    send_tick(make_tick(0, 0, 0, 16'h4000));
    idle_wait();

    // full-scale registers, displacement saturation
    stall_mode = STALL_RUNS;
    write_profile('1, '1, '1, '1, '1, '1);
    send_tick(make_tick(16384, -16384, 32767, 16'hFFFF));
    send_tick(make_tick(16384, -16384, 32767, 16'hFFFF));
    send_tick(make_tick(-32768, 16384, 0, 16'hFFFF));
    send_tick(make_tick(0, 0, 0, 16'hFFFF));
    idle_wait();

    // zero limits pull every axis to rest
    write_profile('0, '0, '0, '0, '0, '0);
    send_tick(make_tick(16384, 16384, 16384, 16'hFFFF));
    send_tick(make_tick(0, 0, 0, 16'hFFFF));
    idle_wait();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      stall_mode = stall_mode_t'(p % 4);
      gap_max = (p % 3 == 1) ? 0 : $urandom_range(2, 7);
      write_profile(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
      repeat (TICKS_PER_PHASE)
        send_tick(make_tick(rand_drive(), rand_drive(), rand_drive(), rand_time()));
      idle_wait();
    end

    $display("%0d tick requests under %0d register profiles, %0d results compared",
             ticks_sent, profiles_loaded, results_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("three_axis_velocity_ramp test passed");
    end else begin
      $display("three_axis_velocity_ramp test failed");
    end
    $finish;
  end

endmodule
